@@ rtl/bzr_pkg.sv @@
// ----------------------------------------------------------------------------
// Cubic Bezier point generator package
// Shared widths, defaults and the per-point tag that rides the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package bzr_pkg;

   // Defaults for the top level parameters.
   localparam int COORD_WIDTH_DEF = 24;
   localparam int MAX_POINTS_DEF  = 63;

   // Fixed field widths of a segment transaction.
   localparam int COUNT_W = 6;
   localparam int STEP_W  = 16;

   // Curve parameter t = i*step: unsigned, 16 fraction bits, at most 22 bits wide.
   localparam int T_W    = 22;
   localparam int T_FRAC = 16;

   // Horner accumulator saturates to [-(2^40), 2^40 - 1].
   localparam int ACC_W  = 41;
   // Full product of accumulator and t, and the rounded sum after the shift.
   localparam int PROD_W = 64;
   localparam int SUM_W  = PROD_W - T_FRAC;

   // Number of register stages from the issue register to the last Horner add.
   localparam int PIPE_STAGES = 7;
   localparam int HORNER_STEPS = 3;

   typedef struct packed {
      logic is_end;   // result is the appended fourth control point
      logic last;     // final result of the segment
   } point_tag_type;

endpackage : bzr_pkg

`default_nettype wire

@@ rtl/cubic_bezier_point_generator_unit.sv @@
// ----------------------------------------------------------------------------
// Cubic Bezier point generator
// Expands one cubic segment into points by Horner's rule in a register pipeline.
// ----------------------------------------------------------------------------
// Each result passes the issue register, the Horner pipeline stages and the output register.
// Throughput: one result per cycle within a segment while no result waits at the output;
// a segment holds the input until its last point is issued, since the sequencer issues one
// point per cycle into the pipeline. A segment that causes no result leaves the input free.
// Reset (synchronous, active high) empties the sequencer and every pipeline stage.
`default_nettype none

module cubic_bezier_point_generator_unit #(
   parameter int COORD_WIDTH = bzr_pkg::COORD_WIDTH_DEF,
   parameter int MAX_POINTS  = bzr_pkg::MAX_POINTS_DEF,
   localparam int REQ_BITS   = 8 * COORD_WIDTH + bzr_pkg::COUNT_W + bzr_pkg::STEP_W + 1,
   localparam int REQ_W      = ((REQ_BITS + 7) / 8) * 8,
   localparam int RSP_W      = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // start_x, start_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, finish_x, finish_y,
   // point_count, param_step, append_end
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [REQ_W-1:0]   req_tdata,
   // point_x, point_y
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [RSP_W-1:0]        rsp_tdata,
   // is_end_point
   output logic                    rsp_tuser,
   // last_of_run
   output logic                    rsp_tlast
);
   import bzr_pkg::*;

   localparam int CW     = COORD_WIDTH;
   localparam int COEF_W = COORD_WIDTH + 4;
   localparam int OFS_COUNT  = 8 * CW;
   localparam int OFS_STEP   = OFS_COUNT + COUNT_W;
   localparam int OFS_APPEND = OFS_STEP + STEP_W;

   typedef struct packed {
      logic signed [COEF_W-1:0] a;
      logic signed [COEF_W-1:0] b;
      logic signed [COEF_W-1:0] c;
      logic signed [CW-1:0]     d;
      logic signed [CW-1:0]     p4;
   } axis_coef_type;

   // ------------------------------------------------------------------------
   // Input field extraction and coefficient forming
   // ------------------------------------------------------------------------
   logic signed [CW-1:0] req_pt [4][2];
   logic [COUNT_W-1:0]   req_count;
   logic [COUNT_W-1:0]   req_count_sat;
   logic [STEP_W-1:0]    req_step;
   logic                 req_append;
   axis_coef_type        req_coef [2];

   always_comb begin
      for (int p = 0; p < 4; p++) begin
         for (int ax = 0; ax < 2; ax++) begin
            req_pt[p][ax] = $signed(req_tdata[(2*p+ax)*CW +: CW]);
         end
      end
      req_count  = req_tdata[OFS_COUNT +: COUNT_W];
      req_step   = req_tdata[OFS_STEP +: STEP_W];
      req_append = req_tdata[OFS_APPEND];
      req_count_sat = (req_count > COUNT_W'(MAX_POINTS)) ? COUNT_W'(MAX_POINTS) : req_count;
   end

   always_comb begin
      logic signed [COEF_W-1:0] p1, p2, p3, p4;
      for (int ax = 0; ax < 2; ax++) begin
         p1 = COEF_W'(req_pt[0][ax]);
         p2 = COEF_W'(req_pt[1][ax]);
         p3 = COEF_W'(req_pt[2][ax]);
         p4 = COEF_W'(req_pt[3][ax]);
         req_coef[ax].a  = (p4 - p1) + ((p2 - p3) <<< 1) + (p2 - p3);
         req_coef[ax].b  = ((p1 + p3) <<< 1) + (p1 + p3) - (p2 <<< 2) - (p2 <<< 1);
         req_coef[ax].c  = ((p2 - p1) <<< 1) + (p2 - p1);
         req_coef[ax].d  = req_pt[0][ax];
         req_coef[ax].p4 = req_pt[3][ax];
      end
   end

   // ------------------------------------------------------------------------
   // Segment sequencer: holds one segment and, while no result waits, issues one point per cycle
   // ------------------------------------------------------------------------
   logic                 advance;
   logic                 busy_ff, busy_in;
   logic [COUNT_W-1:0]   left_ff, left_in;
   logic [T_W-1:0]       t_ff, t_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic                 tail_ff, tail_in;
   axis_coef_type        seg_ff [2];
   axis_coef_type        seg_in [2];
   logic                 issue_valid;
   point_tag_type        issue_tag;

   // The whole pipeline moves together; it stops only while a result waits.
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = !busy_ff;

   always_comb begin
      busy_in     = busy_ff;
      left_in     = left_ff;
      t_in        = t_ff;
      step_in     = step_ff;
      tail_in     = tail_ff;
      seg_in      = seg_ff;
      issue_valid = 1'b0;
      issue_tag   = '0;
      if (!busy_ff) begin
         if (req_tvalid) begin
            seg_in  = req_coef;
            step_in = req_step;
            tail_in = req_append;
            left_in = req_count_sat;
            t_in    = '0;
            busy_in = (req_count_sat != '0) || req_append;
         end
      end else if (advance) begin
         issue_valid = 1'b1;
         if (left_ff != '0) begin
            issue_tag.last = (left_ff == COUNT_W'(1)) && !tail_ff;
            left_in        = left_ff - COUNT_W'(1);
            t_in           = t_ff + T_W'(step_ff);
            if ((left_ff == COUNT_W'(1)) && !tail_ff) begin
               busy_in = 1'b0;
            end
         end else begin
            issue_tag.is_end = 1'b1;
            issue_tag.last   = 1'b1;
            busy_in          = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      left_ff <= left_in;
      t_ff    <= t_in;
      step_ff <= step_in;
      tail_ff <= tail_in;
      seg_ff  <= seg_in;
   end

   // ------------------------------------------------------------------------
   // Horner pipeline: stage 0 issue, then multiply / round-add pairs
   // ------------------------------------------------------------------------
   logic                        vld_ff  [PIPE_STAGES];
   point_tag_type               tag_ff  [PIPE_STAGES];
   logic [T_W-1:0]              tp_ff   [PIPE_STAGES];
   axis_coef_type               co_ff   [PIPE_STAGES][2];
   logic signed [PROD_W-1:0]    prod_ff [HORNER_STEPS][2];
   logic signed [PROD_W-1:0]    prod_in [HORNER_STEPS][2];
   logic signed [ACC_W-1:0]     acc_ff  [HORNER_STEPS][2];
   logic signed [ACC_W-1:0]     acc_in  [HORNER_STEPS][2];

   always_comb begin
      logic signed [ACC_W-1:0]  mul_acc;
      logic signed [T_W:0]      mul_t;
      logic signed [PROD_W-1:0] rnd;
      logic signed [SUM_W-1:0]  sum;
      logic signed [SUM_W-1:0]  coef;
      for (int k = 0; k < HORNER_STEPS; k++) begin
         for (int ax = 0; ax < 2; ax++) begin
            mul_acc = (k == 0) ? ACC_W'($signed(co_ff[0][ax].a)) : acc_ff[(k == 0) ? 0 : k-1][ax];
            mul_t   = $signed({1'b0, tp_ff[2*k]});
            prod_in[k][ax] = mul_acc * mul_t;

            case (k)
               0:       coef = SUM_W'($signed(co_ff[2*k+1][ax].b));
               1:       coef = SUM_W'($signed(co_ff[2*k+1][ax].c));
               default: coef = SUM_W'($signed(co_ff[2*k+1][ax].d));
            endcase
            // Round half up, floor shift, add the next coefficient, saturate to the accumulator.
            rnd = prod_ff[k][ax] + PROD_W'(64'sd1 <<< (T_FRAC - 1));
            sum = $signed(rnd[PROD_W-1:T_FRAC]) + coef;
            if (sum[SUM_W-1:ACC_W-1] == {(SUM_W-ACC_W+1){sum[SUM_W-1]}}) begin
               acc_in[k][ax] = sum[ACC_W-1:0];
            end else begin
               acc_in[k][ax] = sum[SUM_W-1] ? {1'b1, {(ACC_W-1){1'b0}}}
                                            : {1'b0, {(ACC_W-1){1'b1}}};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < PIPE_STAGES; s++) begin
            vld_ff[s] <= 1'b0;
         end
      end else if (advance) begin
         vld_ff[0] <= issue_valid;
         for (int s = 1; s < PIPE_STAGES; s++) begin
            vld_ff[s] <= vld_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         tag_ff[0] <= issue_tag;
         tp_ff[0]  <= t_ff;
         co_ff[0]  <= seg_ff;
         for (int s = 1; s < PIPE_STAGES; s++) begin
            tag_ff[s] <= tag_ff[s-1];
            tp_ff[s]  <= tp_ff[s-1];
            co_ff[s]  <= co_ff[s-1];
         end
         prod_ff <= prod_in;
         acc_ff  <= acc_in;
      end
   end

   // ------------------------------------------------------------------------
   // Output register: coordinate clamp or appended end point
   // ------------------------------------------------------------------------
   localparam int LAST = PIPE_STAGES - 1;

   logic                 rsp_valid_ff;
   logic signed [CW-1:0] point_ff [2];
   logic signed [CW-1:0] point_in [2];
   point_tag_type        rsp_tag_ff;

   always_comb begin
      logic signed [ACC_W-1:0] v;
      for (int ax = 0; ax < 2; ax++) begin
         v = acc_ff[HORNER_STEPS-1][ax];
         if (tag_ff[LAST].is_end) begin
            point_in[ax] = co_ff[LAST][ax].p4;
         end else if (v[ACC_W-1:CW-1] == {(ACC_W-CW+1){v[ACC_W-1]}}) begin
            point_in[ax] = v[CW-1:0];
         end else begin
            point_in[ax] = v[ACC_W-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= vld_ff[LAST];
      end
      if (advance) begin
         point_ff   <= point_in;
         rsp_tag_ff <= tag_ff[LAST];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({point_ff[1], point_ff[0]});
   assign rsp_tuser  = rsp_tag_ff.is_end;
   assign rsp_tlast  = rsp_tag_ff.last;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   // The appended end point always closes its segment.
   a_end_is_last : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("end point result without last marker");

   // A busy sequencer with no evaluated points left must owe the end point.
   a_busy_tail : assert property (@(posedge clock) disable iff (reset)
      busy_ff && (left_ff == '0) |-> tail_ff)
      else $error("sequencer busy with nothing left to issue");

   // A segment that causes results keeps the sequencer busy on the next cycle.
   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && ((req_count_sat != '0) || req_append) |=> busy_ff)
      else $error("accepted segment did not start the sequencer");

   // An issued point enters stage 0 on the following edge.
   a_issue_enters : assert property (@(posedge clock) disable iff (reset)
      issue_valid |=> vld_ff[0])
      else $error("issued point lost before the pipeline");

endmodule : cubic_bezier_point_generator_unit

`default_nettype wire

@@ dv/cubic_bezier_point_generator_unit_tb.sv @@
// ----------------------------------------------------------------------------
// Cubic Bezier point generator testbench
// Drives cubic segments into the stream input and predicts every curve point
// with a fixed-point Horner evaluator of its own. Each output transaction is
// compared field by field with the oldest predicted point. Both sides idle at
// random, the output is held off long enough to back up the input, and the
// sender pauses until all predicted points have drained.
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_bezier_point_generator_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bzr_pkg::*;

   localparam int CW           = COORD_WIDTH_DEF;
   localparam int MAX_PTS      = MAX_POINTS_DEF;
   localparam int REQ_BITS     = 8 * CW + COUNT_W + STEP_W + 1;
   localparam int REQ_W        = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_W        = ((2 * CW + 7) / 8) * 8;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 20;
   localparam int PRINT_LIMIT  = 50;

   localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};
   localparam longint ACC_LIM = longint'(1) << (ACC_W - 1);

   // The first member lands in the highest bits, so start_x ends up at bit 0.
   typedef struct packed {
      logic                 append_end;
      logic [STEP_W-1:0]    param_step;
      logic [COUNT_W-1:0]   point_count;
      logic signed [CW-1:0] finish_y;
      logic signed [CW-1:0] finish_x;
      logic signed [CW-1:0] ctrl2_y;
      logic signed [CW-1:0] ctrl2_x;
      logic signed [CW-1:0] ctrl1_y;
      logic signed [CW-1:0] ctrl1_x;
      logic signed [CW-1:0] start_y;
      logic signed [CW-1:0] start_x;
   } segment_type;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic                 is_end;
      logic                 last;
   } bezier_point_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tuser;
   logic             rsp_tlast;

   bezier_point_type expected_points[$];
   bezier_point_type exp_pt;
   int unsigned   error_count = 0;
   int unsigned   segments_sent = 0;
   int unsigned   empty_segments = 0;
   int unsigned   points_checked = 0;
   int unsigned   idle_cycles = 0;
   int unsigned   tx_idle_max = 0;
   int unsigned   rx_idle_max = 0;
   int unsigned   rx_hold_req = 0;

   cubic_bezier_point_generator_unit #(
      .COORD_WIDTH (CW),
      .MAX_POINTS  (MAX_PTS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   // One Horner stage: round the product half up, add the coefficient, clamp.
   function automatic longint horner_round_add(longint acc, longint t, longint coef);
      longint r;
      r = ((acc * t + (longint'(1) << (T_FRAC - 1))) >>> T_FRAC) + coef;
      if (r < -ACC_LIM) begin
         r = -ACC_LIM;
      end else if (r > ACC_LIM - 1) begin
         r = ACC_LIM - 1;
      end
      return r;
   endfunction

   function automatic logic signed [CW-1:0] bezier_axis_value(longint p1, longint p2,
                                                               longint p3, longint p4,
                                                               longint t);
      longint acc;
      acc = -p1 + 3 * p2 - 3 * p3 + p4;
      acc = horner_round_add(acc, t, 3 * p1 - 6 * p2 + 3 * p3);
      acc = horner_round_add(acc, t, -3 * p1 + 3 * p2);
      acc = horner_round_add(acc, t, p1);
      if (acc > longint'(COORD_MAX)) begin
         acc = longint'(COORD_MAX);
      end else if (acc < longint'(COORD_MIN)) begin
         acc = longint'(COORD_MIN);
      end
      return CW'(acc);
   endfunction

   function automatic void predict_segment_points(segment_type seg);
      int unsigned      n;
      longint           t;
      bezier_point_type pt;
      n = (seg.point_count > MAX_PTS) ? MAX_PTS : seg.point_count;
      for (int unsigned i = 0; i < n; i++) begin
         t = longint'(i) * longint'(seg.param_step);
         pt.x = bezier_axis_value(longint'(seg.start_x), longint'(seg.ctrl1_x),
                                  longint'(seg.ctrl2_x), longint'(seg.finish_x), t);
         pt.y = bezier_axis_value(longint'(seg.start_y), longint'(seg.ctrl1_y),
                                  longint'(seg.ctrl2_y), longint'(seg.finish_y), t);
         pt.is_end = 1'b0;
         pt.last = !seg.append_end && (i + 1 == n);
         expected_points.insert(expected_points.size(), pt);
      end
      if (seg.append_end) begin
         pt.x = seg.finish_x;
         pt.y = seg.finish_y;
         pt.is_end = 1'b1;
         pt.last = 1'b1;
         expected_points.insert(expected_points.size(), pt);
      end
      if (n == 0 && !seg.append_end) begin
         empty_segments++;
      end
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic segment_type build_segment(
         logic signed [CW-1:0] x1, logic signed [CW-1:0] y1,
         logic signed [CW-1:0] x2, logic signed [CW-1:0] y2,
         logic signed [CW-1:0] x3, logic signed [CW-1:0] y3,
         logic signed [CW-1:0] x4, logic signed [CW-1:0] y4,
         int unsigned count, int unsigned step,
         logic append);
      segment_type seg;
      seg.start_x = x1;
      seg.start_y = y1;
      seg.ctrl1_x = x2;
      seg.ctrl1_y = y2;
      seg.ctrl2_x = x3;
      seg.ctrl2_y = y3;
      seg.finish_x = x4;
      seg.finish_y = y4;
      seg.point_count = COUNT_W'(count);
      seg.param_step = STEP_W'(step);
      seg.append_end = append;
      return seg;
   endfunction

   // Leaves tvalid high on return so that a following segment can go out
   // back to back; callers lower it with stop_sending before they pause.
   task automatic send_segment(segment_type seg);
      int unsigned gap;
      gap = (tx_idle_max != 0) ? $urandom_range(0, tx_idle_max) : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= REQ_W'(seg);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      segments_sent++;
      predict_segment_points(seg);
   endtask

   task automatic stop_sending();
      req_tvalid <= 1'b0;
   endtask

   task automatic wait_results_drained();
      while (expected_points.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [CW-1:0] random_coord(int unsigned style);
      case (style)
         0: begin
            return CW'($urandom);
         end
         1: begin
            return CW'(int'($urandom_range(0, 8191)) - 4096);
         end
         default: begin
            return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
         end
      endcase
   endfunction

   function automatic segment_type random_segment();
      int unsigned style;
      int unsigned count;
      int unsigned step;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
         count = 0;
      end else if (pick < 70) begin
         count = $urandom_range(1, 12);
      end else if (pick < 90) begin
         count = $urandom_range(13, 40);
      end else begin
         count = $urandom_range(41, 63);
      end
      // Keep t inside the unit interval for a part of the segments.
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
         step = $urandom_range(0, 65535);
      end else if (pick < 9) begin
         step = $urandom_range(0, 65535 / ((count > 1) ? count - 1 : 1));
      end else begin
         step = $urandom_range(0, 255);
      end
      pick = $urandom_range(0, 9);
      style = (pick < 5) ? 0 : (pick < 9) ? 1 : 2;
      return build_segment(random_coord(style), random_coord(style),
                           random_coord(style), random_coord(style),
                           random_coord(style), random_coord(style),
                           random_coord(style), random_coord(style),
                           count, step, 1'($urandom_range(0, 1)));
   endfunction

   // ---------------------------------------------------------------- tests

   task automatic test_directed_cases();
      tx_idle_max = 0;
      rx_idle_max = 14;
      send_segment(build_segment('0, '0, '0, '0, '0, '0, '0, '0, 1, 0, 1'b0));
      send_segment(build_segment(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                                 COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 63, 65535, 1'b1));
      send_segment(build_segment(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                                 COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, 63, 65535, 1'b1));
      // Alternating extremes drive the accumulator into its own clamp.
      send_segment(build_segment(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
                                 COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 63, 65535, 1'b0));
      send_segment(build_segment(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN,
                                 COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, 40, 40000, 1'b1));
      // A zero count gives nothing, or only the end point.
      send_segment(build_segment(24'sd100, 24'sd200, 24'sd300, 24'sd400,
                                 24'sd500, 24'sd600, 24'sd700, 24'sd800, 0, 1000, 1'b0));
      send_segment(build_segment(24'sd100, 24'sd200, 24'sd300, 24'sd400,
                                 24'sd500, 24'sd600, COORD_MAX, COORD_MIN, 0, 1000, 1'b1));
      send_segment(build_segment(-24'sd5000, 24'sd7000, 24'sd1, -24'sd1,
                                 24'sd90000, -24'sd90000, 24'sd3, 24'sd4, 5, 0, 1'b1));
      send_segment(build_segment(24'sd0, 24'sd0, 24'sd25600, 24'sd51200,
                                 24'sd76800, -24'sd51200, 24'sd102400, 24'sd0, 63, 1040, 1'b1));
      send_segment(build_segment(24'sd12345, -24'sd23456, 24'sd34567, -24'sd45678,
                                 24'sd56789, -24'sd67890, 24'sd78901, -24'sd89012, 63, 1, 1'b0));
      send_segment(build_segment(24'sd9, 24'sd8, 24'sd7, 24'sd6,
                                 24'sd5, 24'sd4, 24'sd3, 24'sd2, 1, 65535, 1'b1));
      send_segment(build_segment(-24'sd256, -24'sd512, -24'sd768, -24'sd1024,
                                 -24'sd1280, -24'sd1536, -24'sd1792, -24'sd2048, 5, 16384, 1'b0));
      // Step of one half runs t far past one, so the cubic extrapolates.
      send_segment(build_segment(24'sd1000, -24'sd1000, 24'sd40000, 24'sd3000,
                                 -24'sd2000, 24'sd50000, 24'sd700, -24'sd800, 63, 32768, 1'b1));
      stop_sending();
      wait_results_drained();
   endtask

   task automatic test_random_segments();
      for (int chunk = 0; chunk < 5; chunk++) begin
         tx_idle_max = $urandom_range(0, 1) ? 14 : 0;
         rx_idle_max = $urandom_range(0, 1) ? 14 : 0;
         repeat (17) send_segment(random_segment());
      end
      stop_sending();
      wait_results_drained();
   endtask

   task automatic test_output_backpressure();
      tx_idle_max = 0;
      rx_idle_max = 3;
      rx_hold_req = 300;
      repeat (8) send_segment(random_segment());
      stop_sending();
      wait_results_drained();
   endtask

   task automatic test_pause_until_drained();
      tx_idle_max = 14;
      rx_idle_max = 14;
      repeat (3) send_segment(random_segment());
      stop_sending();
      wait_results_drained();
      repeat (3) send_segment(random_segment());
      stop_sending();
      wait_results_drained();
   endtask

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= PRINT_LIMIT) begin
         $display("[%0t] MISMATCH: %s", $time, what);
      end
   endtask

   initial begin : result_receiver
      int unsigned pause;
      while (reset) @(posedge clock);
      forever begin
         pause = rx_hold_req + ((rx_idle_max != 0) ? $urandom_range(0, rx_idle_max) : 0);
         rx_hold_req = 0;
         if (pause != 0) begin
            rsp_tready <= 1'b0;
            repeat (pause) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         points_checked++;
         if (expected_points.size() == 0) begin
            report_mismatch($sformatf("unexpected point x=%h y=%h",
                                      rsp_tdata[CW-1:0], rsp_tdata[2*CW-1:CW]));
         end else begin
            exp_pt = expected_points.pop_front();
            if (rsp_tdata[CW-1:0] !== exp_pt.x) begin
               report_mismatch($sformatf("point_x got %h expected %h",
                                         rsp_tdata[CW-1:0], exp_pt.x));
            end
            if (rsp_tdata[2*CW-1:CW] !== exp_pt.y) begin
               report_mismatch($sformatf("point_y got %h expected %h",
                                         rsp_tdata[2*CW-1:CW], exp_pt.y));
            end
            if (rsp_tuser !== exp_pt.is_end) begin
               report_mismatch($sformatf("is_end_point got %b expected %b",
                                         rsp_tuser, exp_pt.is_end));
            end
            if (rsp_tlast !== exp_pt.last) begin
               report_mismatch($sformatf("last_of_run got %b expected %b",
                                         rsp_tlast, exp_pt.last));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Timeout after %0d cycles without a transaction", IDLE_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_random_segments();
      test_output_backpressure();
      test_pause_until_drained();
      wait_results_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d segments (%0d without any point) and checked %0d points.",
               segments_sent, empty_segments, points_checked);
      $display("Run included saturating extremes, zero counts, extrapolated t and stalls.");
      if (error_count == 0 && expected_points.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d mismatches, %0d points never arrived",
                  error_count, expected_points.size());
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/bzr_pkg.sv
rtl/cubic_bezier_point_generator_unit.sv
dv/cubic_bezier_point_generator_unit_tb.sv
